// ===== sv/pcx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcx_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] COUNT_MARK = 8'd192;

    // Queue operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_PALETTE_ENABLE = 1'b0;
    localparam logic REG_OUTPUT_UNITS   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic        use_palette;
        logic [7:0]  addr;
        logic [23:0] colour;
        logic [5:0]  run;
        logic        done;
    } pcx_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pcx_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/pcx_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcx_fifo #(
    parameter int DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcx_pkg::pcx_cmd_t push_data,
    input  wire logic             pop,
    output pcx_pkg::pcx_cmd_t     head,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcx_pkg::pcx_cmd_t slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pcx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcx_front #(
    parameter int PALETTE_DEPTH = pcx_pkg::PALETTE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              palette_enable,
    input  wire logic [31:0]       output_units,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [7:0]        data_byte,
    input  wire logic [7:0]        entry_index,
    input  wire logic [7:0]        entry_red,
    input  wire logic [7:0]        entry_green,
    input  wire logic [7:0]        entry_blue,
    output logic                   push,
    output pcx_pkg::pcx_cmd_t      push_data
);

    logic        pending_reg, pending_next;
    logic [5:0]  run_length_reg, run_length_next;
    logic [31:0] units_reg, units_next;
    logic        stopped_reg, stopped_next;

    logic        have_run;
    logic [5:0]  run;
    logic [32:0] units_sum;
    logic        in_range;

    assign units_sum = {1'b0, units_reg} + 33'(run);
    assign in_range  = ({1'b0, data_byte} < 9'(PALETTE_DEPTH));

    always_comb
    begin
        pending_next    = pending_reg;
        run_length_next = run_length_reg;
        units_next      = units_reg;
        stopped_next    = stopped_reg;
        have_run        = 1'b0;
        run             = 6'd1;
        push            = 1'b0;

        push_data             = '0;
        push_data.addr        = data_byte;
        push_data.use_palette = palette_enable && in_range;
        push_data.colour      = palette_enable ? 24'd0 : {data_byte, 16'd0};
        push_data.run         = run;

        if (accept)
        begin
            if (kind)
            begin
                push_data.op     = pcx_pkg::OP_WRITE;
                push_data.addr   = entry_index;
                push_data.colour = {entry_red, entry_green, entry_blue};
                push = ({1'b0, entry_index} < 9'(PALETTE_DEPTH));
            end
            else if (!stopped_reg && (units_reg < output_units))
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    run          = run_length_reg;
                    have_run     = 1'b1;
                end
                else if (data_byte >= pcx_pkg::COUNT_MARK)
                begin
                    run_length_next = data_byte[5:0];
                    pending_next    = 1'b1;
                end
                else
                begin
                    have_run = 1'b1;
                end
            end
        end

        push_data.run = run;

        // A zero-length run consumes its value byte and yields nothing.
        if (have_run && (run != 6'd0))
        begin
            push = 1'b1;
            if (units_sum > {1'b0, output_units})
            begin
                stopped_next          = 1'b1;
                push_data.op          = pcx_pkg::OP_ERROR;
                push_data.use_palette = 1'b0;
            end
            else
            begin
                units_next     = units_sum[31:0];
                push_data.op   = pcx_pkg::OP_RUN;
                push_data.done = (units_sum == {1'b0, output_units});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            run_length_reg <= '0;
            units_reg      <= '0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            run_length_reg <= run_length_next;
            units_reg      <= units_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pcx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcx_back #(
    parameter int PALETTE_DEPTH = pcx_pkg::PALETTE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire pcx_pkg::pcx_cmd_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             pixel_red,
    output logic [7:0]             pixel_green,
    output logic [7:0]             pixel_blue,
    output logic                   run_last,
    output logic                   image_done,
    output logic                   overflow_error
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic        state_reg, state_next;
    logic [5:0]  left_reg, left_next;
    logic        done_reg, done_next;
    logic        pal_reg, pal_next;
    logic [23:0] colour_reg, colour_next;

    logic        valid_reg, valid_next;
    logic [23:0] rgb_reg, rgb_next;
    logic        last_reg, last_next;
    logic        img_reg, img_next;
    logic        err_reg, err_next;
    logic        load;

    logic          ram_we;
    logic          ram_re;
    logic [23:0]   ram_rdata;
    logic          out_free;
    logic          is_last;
    logic [23:0]   colour;

    pcx_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.addr[AW-1:0]),
        .wdata (head.colour),
        .re    (ram_re),
        .raddr (head.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = !valid_reg || out_ready;
    assign is_last  = (left_reg == 6'd1);
    // The RAM output holds between reads, so it serves the whole run.
    assign colour   = pal_reg ? ram_rdata : colour_reg;

    always_comb
    begin
        state_next  = state_reg;
        left_next   = left_reg;
        done_next   = done_reg;
        pal_next    = pal_reg;
        colour_next = colour_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load        = 1'b0;
        rgb_next    = rgb_reg;
        last_next   = last_reg;
        img_next    = img_reg;
        err_next    = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    case (head.op)
                        pcx_pkg::OP_WRITE:
                        begin
                            pop    = 1'b1;
                            ram_we = 1'b1;
                        end
                        pcx_pkg::OP_RUN:
                        begin
                            pop         = 1'b1;
                            ram_re      = head.use_palette;
                            left_next   = head.run;
                            done_next   = head.done;
                            pal_next    = head.use_palette;
                            colour_next = head.colour;
                            state_next  = ST_EMIT;
                        end
                        pcx_pkg::OP_ERROR:
                        begin
                            if (out_free)
                            begin
                                pop       = 1'b1;
                                load      = 1'b1;
                                rgb_next  = '0;
                                last_next = 1'b1;
                                img_next  = 1'b0;
                                err_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    rgb_next  = colour;
                    last_next = is_last;
                    img_next  = done_reg && is_last;
                    err_next  = 1'b0;
                    left_next = left_reg - 6'd1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        done_reg   <= done_next;
        pal_reg    <= pal_next;
        colour_reg <= colour_next;
        rgb_reg    <= rgb_next;
        last_reg   <= last_next;
        img_reg    <= img_next;
        err_reg    <= err_next;
    end

    assign out_valid      = valid_reg;
    assign pixel_red      = rgb_reg[23:16];
    assign pixel_green    = rgb_reg[15:8];
    assign pixel_blue     = rgb_reg[7:0];
    assign run_last       = last_reg;
    assign image_done     = img_reg;
    assign overflow_error = err_reg;

endmodule

`default_nettype wire

// ===== sv/pcx_rle_palette_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    kind, data_byte, entry_index, entry_red/green/blue
// out       output     out_valid/out_ready  pixel_red/green/blue, run_last, image_done,
//                                           overflow_error
// config    input      APB psel/penable     paddr, pwdata, prdata (registers at 0 and 4)
//
// The front takes one transaction per cycle while the command queue has room.
// The back pops each command and, for a palette run, starts the palette read;
// a run then emits its results in turn, and the next command is popped only
// after the run's last result is loaded; a palette write only writes the RAM.
// Reset is asynchronous and active low; there is no clearing pass.
// A stalled output holds the back, and a full queue drops in_ready.

module pcx_rle_palette_decoder #(
    parameter int PALETTE_DEPTH = pcx_pkg::PALETTE_DEPTH,
    parameter int QUEUE_DEPTH   = pcx_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  entry_index,
    input  wire logic [7:0]  entry_red,
    input  wire logic [7:0]  entry_green,
    input  wire logic [7:0]  entry_blue,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pixel_red,
    output logic [7:0]       pixel_green,
    output logic [7:0]       pixel_blue,
    output logic             run_last,
    output logic             image_done,
    output logic             overflow_error,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        palette_enable_reg;
    logic [31:0] output_units_reg;
    logic        cfg_write;

    logic              q_push;
    pcx_pkg::pcx_cmd_t q_push_data;
    logic              q_pop;
    pcx_pkg::pcx_cmd_t q_head;
    logic              q_full;
    logic              q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_enable_reg <= 1'b0;
            output_units_reg   <= 32'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                pcx_pkg::REG_PALETTE_ENABLE: palette_enable_reg <= pwdata[0];
                pcx_pkg::REG_OUTPUT_UNITS:   output_units_reg   <= pwdata;
                default:                     palette_enable_reg <= palette_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            pcx_pkg::REG_PALETTE_ENABLE: prdata = {31'd0, palette_enable_reg};
            pcx_pkg::REG_OUTPUT_UNITS:   prdata = output_units_reg;
            default:                     prdata = '0;
        endcase
    end

    assign in_ready = !q_full;

    pcx_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .palette_enable (palette_enable_reg),
        .output_units   (output_units_reg),
        .accept         (in_valid && in_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .entry_index    (entry_index),
        .entry_red      (entry_red),
        .entry_green    (entry_green),
        .entry_blue     (entry_blue),
        .push           (q_push),
        .push_data      (q_push_data)
    );

    pcx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pcx_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (q_empty),
        .head           (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_red      (pixel_red),
        .pixel_green    (pixel_green),
        .pixel_blue     (pixel_blue),
        .run_last       (run_last),
        .image_done     (image_done),
        .overflow_error (overflow_error)
    );

endmodule

`default_nettype wire

// ===== sv/pcx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  pixel_red,
    input wire logic [7:0]  pixel_green,
    input wire logic [7:0]  pixel_blue,
    input wire logic        run_last,
    input wire logic        image_done,
    input wire logic        overflow_error
);

    logic error_seen_reg;

    // Once an error transaction has gone out, the decoder stays stopped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && overflow_error)
        begin
            error_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_red)
            && $stable(pixel_green) && $stable(pixel_blue) && $stable(run_last)
            && $stable(image_done) && $stable(overflow_error))
        else $error("output changed while stalled");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_error |-> run_last && !image_done
            && pixel_red == 8'd0 && pixel_green == 8'd0 && pixel_blue == 8'd0)
        else $error("malformed error result");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> run_last && !overflow_error)
        else $error("image completed in the middle of a run");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_seen_reg |-> !out_valid)
        else $error("result after an overflow error");

endmodule

bind pcx_rle_palette_decoder pcx_checker u_checker (.*);

`default_nettype wire
